// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and fixed constants shared by the HSV to RGB converter files.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W = 15;
  localparam int CH_W  = 8;
  localparam int REM_W = 12;

  // One full turn and one 60 degree sector, in 1/64 degree units
  localparam logic [HUE_W-1:0] HUE_TURN   = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;

  // 255 * 256
  localparam logic [15:0] PROD_SCALE = 16'd65280;
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [8:0]  FRAC_SCALE = 9'd256;

  // ceil(2^16 / 15): exact floor(x / 15) for x < 4681
  localparam logic [12:0] RECIP15  = 13'd4370;
  // ceil(2^23 / 255): exact floor(x / 255) for x < 66052
  localparam logic [15:0] RECIP255 = 16'd32897;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

// ===== rtl/hsv2rgb_in_if.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_in_if
// Valid/ready channel carrying one HSV pixel per transaction.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
  logic                          valid;
  logic                          ready;
  logic [hsv2rgb_pkg::HUE_W-1:0] hue;
  logic [hsv2rgb_pkg::CH_W-1:0]  saturation;
  logic [hsv2rgb_pkg::CH_W-1:0]  brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== rtl/hsv2rgb_out_if.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_out_if
// Valid/ready channel carrying one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface hsv2rgb_out_if;
  logic                         valid;
  logic                         ready;
  logic [hsv2rgb_pkg::CH_W-1:0] red;
  logic [hsv2rgb_pkg::CH_W-1:0] green;
  logic [hsv2rgb_pkg::CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Six-stage pipelined HSV to RGB pixel converter with valid/ready channels.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; the six stage registers are the pipeline,
//   each stage holds while the stage after it is full and stalled.
// Reset: rst_n (synchronous, active low) empties every stage; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  hsv2rgb_in_if.sink           in_pix,
  hsv2rgb_out_if.source        out_pix
);
  import hsv2rgb_pkg::*;

  localparam int NSTG = 6;

  // Stage occupancy and per-stage load enables. A stage takes new data when
  // it is empty or when its content moves on in the same cycle.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_pix.ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_pix.valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_pix.ready  = rdy[0];
  assign out_pix.valid = vld_r[NSTG-1];

  // --------------------------------------------------------------------------
  // Stage 1: zero a hue at or past a full turn, find the sector by compare
  // against the sector boundaries and strip it off for the in-sector offset.
  // --------------------------------------------------------------------------
  logic [HUE_W-1:0] hue_w;
  logic [HUE_W-1:0] sec_base;
  logic [HUE_W-1:0] hue_off;
  sector_t          sec_c;

  always_comb begin
    hue_w    = (in_pix.hue >= HUE_TURN) ? '0 : in_pix.hue;
    sec_c    = SEC_RED_YEL;
    sec_base = '0;
    for (int k = 1; k < 6; k++) begin
      if (hue_w >= HUE_W'(k * 3840)) begin
        sec_c    = sector_t'(3'(k));
        sec_base = HUE_W'(k * 3840);
      end
    end
    hue_off = hue_w - sec_base;
  end

  sector_t          s1_sec_r;
  logic             s1_gray_r;
  logic [CH_W-1:0]  s1_sat_r;
  logic [CH_W-1:0]  s1_val_r;
  logic [REM_W-1:0] s1_rem_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_sec_r  <= sec_c;
      s1_gray_r <= (in_pix.saturation == '0);
      s1_sat_r  <= in_pix.saturation;
      s1_val_r  <= in_pix.brightness;
      s1_rem_r  <= hue_off[REM_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: fraction f = offset * 256 / 3840 = offset / 15, by reciprocal.
  // --------------------------------------------------------------------------
  logic [REM_W+12:0] frac_prod;
  assign frac_prod = s1_rem_r * RECIP15;

  sector_t         s2_sec_r;
  logic            s2_gray_r;
  logic [CH_W-1:0] s2_sat_r;
  logic [CH_W-1:0] s2_val_r;
  logic [CH_W-1:0] s2_frac_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_sec_r  <= s1_sec_r;
      s2_gray_r <= s1_gray_r;
      s2_sat_r  <= s1_sat_r;
      s2_val_r  <= s1_val_r;
      s2_frac_r <= frac_prod[23:16];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: s*f, s*(256-f) and the p numerator v*(255-s).
  // --------------------------------------------------------------------------
  logic [8:0]  frac_cmp;
  logic [16:0] sat_cmp_prod;
  logic [15:0] sat_frac_prod;
  logic [15:0] p_num;

  assign frac_cmp      = FRAC_SCALE - {1'b0, s2_frac_r};
  assign sat_frac_prod = s2_sat_r * s2_frac_r;
  assign sat_cmp_prod  = s2_sat_r * frac_cmp;
  assign p_num         = s2_val_r * (FULL_SCALE - s2_sat_r);

  sector_t         s3_sec_r;
  logic            s3_gray_r;
  logic [CH_W-1:0] s3_val_r;
  logic [15:0]     s3_sf_r;
  logic [15:0]     s3_sg_r;
  logic [15:0]     s3_pn_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_sec_r  <= s2_sec_r;
      s3_gray_r <= s2_gray_r;
      s3_val_r  <= s2_val_r;
      s3_sf_r   <= sat_frac_prod;
      s3_sg_r   <= sat_cmp_prod[15:0];   // at most 255 * 256
      s3_pn_r   <= p_num;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: q and t numerators, v * (65280 - product).
  // --------------------------------------------------------------------------
  logic [15:0] q_fac;
  logic [15:0] t_fac;
  logic [23:0] q_num;
  logic [23:0] t_num;

  assign q_fac = PROD_SCALE - s3_sf_r;
  assign t_fac = PROD_SCALE - s3_sg_r;
  assign q_num = s3_val_r * q_fac;
  assign t_num = s3_val_r * t_fac;

  sector_t         s4_sec_r;
  logic            s4_gray_r;
  logic [CH_W-1:0] s4_val_r;
  logic [15:0]     s4_pn_r;
  logic [23:0]     s4_qn_r;
  logic [23:0]     s4_tn_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_sec_r  <= s3_sec_r;
      s4_gray_r <= s3_gray_r;
      s4_val_r  <= s3_val_r;
      s4_pn_r   <= s3_pn_r;
      s4_qn_r   <= q_num;
      s4_tn_r   <= t_num;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: divide by 255 (p) and by 65280 (q, t). Dividing by 65280 is a
  // drop of the low byte followed by the same divide by 255.
  // --------------------------------------------------------------------------
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [31:0] prod;
    prod   = x * RECIP255;
    div255 = prod[30:23];
  endfunction

  sector_t         s5_sec_r;
  logic            s5_gray_r;
  logic [CH_W-1:0] s5_val_r;
  logic [CH_W-1:0] s5_p_r;
  logic [CH_W-1:0] s5_q_r;
  logic [CH_W-1:0] s5_t_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_sec_r  <= s4_sec_r;
      s5_gray_r <= s4_gray_r;
      s5_val_r  <= s4_val_r;
      s5_p_r    <= div255(s4_pn_r);
      s5_q_r    <= div255(s4_qn_r[23:8]);
      s5_t_r    <= div255(s4_tn_r[23:8]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: route v, p, q, t to the channels by sector; gray bypass when
  // saturation is zero. These registers drive the output port directly.
  // --------------------------------------------------------------------------
  logic [CH_W-1:0] red_c;
  logic [CH_W-1:0] grn_c;
  logic [CH_W-1:0] blu_c;

  always_comb begin
    case (s5_sec_r)
      SEC_RED_YEL: begin
        red_c = s5_val_r; grn_c = s5_t_r;   blu_c = s5_p_r;
      end
      SEC_YEL_GRN: begin
        red_c = s5_q_r;   grn_c = s5_val_r; blu_c = s5_p_r;
      end
      SEC_GRN_CYN: begin
        red_c = s5_p_r;   grn_c = s5_val_r; blu_c = s5_t_r;
      end
      SEC_CYN_BLU: begin
        red_c = s5_p_r;   grn_c = s5_q_r;   blu_c = s5_val_r;
      end
      SEC_BLU_MAG: begin
        red_c = s5_t_r;   grn_c = s5_p_r;   blu_c = s5_val_r;
      end
      default: begin
        red_c = s5_val_r; grn_c = s5_p_r;   blu_c = s5_q_r;
      end
    endcase
    if (s5_gray_r) begin
      red_c = s5_val_r;
      grn_c = s5_val_r;
      blu_c = s5_val_r;
    end
  end

  logic [CH_W-1:0] red_r;
  logic [CH_W-1:0] grn_r;
  logic [CH_W-1:0] blu_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      red_r <= red_c;
      grn_r <= grn_c;
      blu_r <= blu_c;
    end
  end

  assign out_pix.red   = red_r;
  assign out_pix.green = grn_r;
  assign out_pix.blue  = blu_r;

endmodule

// ===== rtl/hsv2rgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks on the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [hsv2rgb_pkg::CH_W-1:0] out_red,
  input logic [hsv2rgb_pkg::CH_W-1:0] out_green,
  input logic [hsv2rgb_pkg::CH_W-1:0] out_blue
);
  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // Empty pipeline right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A free-running sink never throttles the input side
  a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is free");

  // Fixed latency when the sink keeps taking results
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    ##1 out_ready |=> out_valid)
    else $error("transaction did not arrive after six cycles");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red)
    && $stable(out_green) && $stable(out_blue))
    else $error("stalled output changed");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_red   (out_pix.red),
  .out_green (out_pix.green),
  .out_blue  (out_pix.blue)
);

// ===== tb/hsv_to_rgb_converter_tb.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking testbench for the pipelined HSV to RGB pixel converter.
// A short table of directed pixels (gray, wrap-around, sector corners and
// edges) is followed by a long run of random pixels. Every accepted output
// transaction is compared channel by channel with an expected pixel. Both
// channels idle in random bursts. The receiver holds off once for a long
// stretch; the sender waits for the pipeline to drain twice mid-run and at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;
  import hsv2rgb_pkg::*;

  localparam int NUM_DIRECTED = 23;
  localparam int NUM_RANDOM   = 1880;
  localparam int NUM_PIXELS   = NUM_DIRECTED + NUM_RANDOM;
  localparam int QUIET_PIXELS = 200;   // tail of the run without idling
  localparam int HOLD_AT      = 600;   // pixel count that starts the long holdoff
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_AT     = 1200;  // pixel index where the sender waits for a drain
  localparam int DRAIN_CYCLES = 24;    // wait after the final drain for stray outputs
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // One stimulus row; known marks a row whose expected pixel is typed in.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;
    logic             known;
    rgb_t             want;
  } pixel_row_t;

  // Gray, black, pure sector corners and wrapped hues have an obvious answer;
  // the rest (sector edges, odd saturations) go through the predictor.
  localparam pixel_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{15'd0,     8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},    // black, gray path
    '{15'd32767, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},  // white, all hue bits set
    '{15'd21845, 8'd0,   8'd170, 1'b1, '{8'd170, 8'd170, 8'd170}},  // gray, alternating hue bits
    '{15'd23040, 8'd0,   8'd77,  1'b1, '{8'd77,  8'd77,  8'd77}},   // gray at a full turn
    '{15'd0,     8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},    // red
    '{15'd3840,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},    // yellow
    '{15'd7680,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},    // green
    '{15'd11520, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},  // cyan
    '{15'd15360, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},  // blue
    '{15'd19200, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},  // magenta
    '{15'd23040, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},    // full turn wraps to red
    '{15'd32767, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},    // largest hue wraps too
    '{15'd0,     8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},    // zero value, full sat
    '{15'd23039, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd3839,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd1920,  8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd5760,  8'd1,   8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd9600,  8'd254, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd13440, 8'd170, 8'd85,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd17280, 8'd85,  8'd170, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd21120, 8'd255, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd10922, 8'd200, 8'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd24000, 8'd100, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}}     // wrapped, colored
  };

  logic clk;
  logic rst_n;

  hsv2rgb_in_if  in_pix ();
  hsv2rgb_out_if out_pix ();

  hsv_to_rgb_converter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  pixel_row_t  offered_rows [$];  // driven on the input, not yet accepted
  rgb_t        rgb_expected [$];  // accepted, output not yet seen
  int unsigned pixels_sent;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          quiet_tail;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Compute the RGB pixel for one HSV pixel in fixed point.
  function automatic rgb_t predict_rgb(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat,
                                       logic [CH_W-1:0] bri);
    int unsigned h, s, v, f, p, q, t;
    sector_t     sec;
    rgb_t        px;
    h = 32'(hue);
    s = 32'(sat);
    v = 32'(bri);
    // Zero saturation: gray, hue does not matter.
    if (s == 0) begin
      px = '{bri, bri, bri};
      return px;
    end
    // Full turn or beyond counts as hue zero.
    if (h >= 32'(HUE_TURN)) h = 0;
    sec = sector_t'(3'(h / 32'(HUE_SECTOR)));
    f = ((h % 32'(HUE_SECTOR)) * 32'(FRAC_SCALE)) / 32'(HUE_SECTOR);
    p = (v * (32'(FULL_SCALE) - s)) / 32'(FULL_SCALE);
    q = (v * (32'(PROD_SCALE) - s * f)) / 32'(PROD_SCALE);
    t = (v * (32'(PROD_SCALE) - s * (32'(FRAC_SCALE) - f))) / 32'(PROD_SCALE);
    case (sec)
      SEC_RED_YEL: px = '{CH_W'(v), CH_W'(t), CH_W'(p)};
      SEC_YEL_GRN: px = '{CH_W'(q), CH_W'(v), CH_W'(p)};
      SEC_GRN_CYN: px = '{CH_W'(p), CH_W'(v), CH_W'(t)};
      SEC_CYN_BLU: px = '{CH_W'(p), CH_W'(q), CH_W'(v)};
      SEC_BLU_MAG: px = '{CH_W'(t), CH_W'(p), CH_W'(v)};
      default:     px = '{CH_W'(v), CH_W'(p), CH_W'(q)};
    endcase
    return px;
  endfunction

  // Draw a random pixel: mostly in-range hues, some wrapped, some right at
  // sector edges; saturation and value lean toward their extremes now and then.
  function automatic pixel_row_t draw_pixel();
    pixel_row_t row;
    int unsigned pick;
    int unsigned offset;
    row = '0;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      row.hue = HUE_W'($urandom_range(23040, 32767));
    end else if (pick <= 2) begin
      offset = $urandom_range(0, 1) ? $urandom_range(0, 2) : 3837 + $urandom_range(0, 2);
      row.hue = HUE_W'($urandom_range(0, 5) * 3840 + offset);
    end else begin
      row.hue = HUE_W'($urandom_range(0, 23039));
    end
    pick = $urandom_range(0, 9);
    if (pick == 0)      row.saturation = '0;
    else if (pick == 1) row.saturation = '1;
    else                row.saturation = CH_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick == 0)      row.brightness = '0;
    else if (pick == 1) row.brightness = '1;
    else                row.brightness = CH_W'($urandom_range(0, 255));
    return row;
  endfunction

  task automatic check_channel(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Watchdog: end the run if the pipeline never drains.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result sink: random stall bursts, one long holdoff, no stalls in the tail.
  initial begin : pixel_sink
    int unsigned burst;
    bit          hold_done;
    hold_done = 1'b0;
    out_pix.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!hold_done && pixels_sent >= HOLD_AT) begin
        // Hold off long enough to fill every stage and back up the input.
        hold_done = 1'b1;
        out_pix.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_pix.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_pix.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Monitor: turn each accepted input transaction into an expected pixel, and
  // compare each accepted output transaction with the oldest one. Push before
  // pop so that even a combinational path would line up.
  always @(posedge clk) begin : pixel_monitor
    pixel_row_t row;
    rgb_t       want;
    if (rst_n) begin
      if (in_pix.valid && in_pix.ready) begin
        row = offered_rows.pop_front();
        if (row.known) rgb_expected.push_back(row.want);
        else rgb_expected.push_back(predict_rgb(in_pix.hue, in_pix.saturation,
                                                in_pix.brightness));
      end
      if (out_pix.valid && out_pix.ready) begin
        if (rgb_expected.size() == 0) begin
          $error("output transaction with no pixel outstanding: r=%0d g=%0d b=%0d",
                 out_pix.red, out_pix.green, out_pix.blue);
          mismatches++;
        end else begin
          want = rgb_expected.pop_front();
          check_channel("red",   want.red,   out_pix.red);
          check_channel("green", want.green, out_pix.green);
          check_channel("blue",  want.blue,  out_pix.blue);
        end
      end
    end
  end

  // Pixel source and run control.
  initial begin : pixel_source
    pixel_row_t  row;
    int unsigned gap;
    pixels_sent = 0;
    mismatches  = 0;
    quiet_tail  = 1'b0;
    rst_n              <= 1'b0;
    in_pix.valid       <= 1'b0;
    in_pix.hue         <= '0;
    in_pix.saturation  <= '0;
    in_pix.brightness  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_PIXELS; i++) begin
      row = (i < NUM_DIRECTED) ? DIRECTED_ROWS[i] : draw_pixel();
      if (i == NUM_DIRECTED || i == DRAIN_AT) begin
        // Drop valid and wait until every accepted pixel has come out.
        in_pix.valid <= 1'b0;
        @(posedge clk);
        while (rgb_expected.size() != 0) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 5);
        in_pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      quiet_tail = (i >= NUM_PIXELS - QUIET_PIXELS);

      // Offer the pixel and hold it until the transaction completes.
      offered_rows.push_back(row);
      in_pix.valid      <= 1'b1;
      in_pix.hue        <= row.hue;
      in_pix.saturation <= row.saturation;
      in_pix.brightness <= row.brightness;
      do @(posedge clk); while (!in_pix.ready);
      pixels_sent++;
    end

    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (rgb_expected.size() != 0) @(posedge clk);
    // Keep running to catch stray output transactions.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
